FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define AST_NXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/mkle_pkg.sv
package mkle_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_SHORT = 2'd0;
    localparam logic [1:0] FUNC_LONG  = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;
    localparam logic [1:0] FUNC_KEY   = 2'd3;

    // Editing keys
    localparam logic [7:0] K_BS    = 8'h08;
    localparam logic [7:0] K_DEL   = 8'h7f;
    localparam logic [7:0] K_LEFT  = 8'h11;
    localparam logic [7:0] K_RIGHT = 8'h13;

    localparam logic [7:0] PAT_START = 8'h02;
    localparam logic [1:0] LAST_ROW  = 2'd3;
    localparam logic [3:0] LAST_COL  = 4'd10;

    // Position width wide enough for the deepest line
    localparam int POS_W = 9;

    // Cell operations
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] pos;
        logic [7:0]       ch;
    } t_cell_ctl;

    typedef logic [7:0] t_rom_row [0:10];

    // Morse patterns per set, [set][row][col]
    localparam t_rom_row CODE_ROM [0:2][0:3] = '{
        '{
            '{8'h30,8'h38,8'h3c,8'h3e,8'h3f,8'h2f,8'h27,8'h23,8'h21,8'h20,8'h10},
            '{8'h12,8'h0c,8'h03,8'h0d,8'h02,8'h14,8'h0e,8'h07,8'h08,8'h19,8'h00},
            '{8'h06,8'h0f,8'h0b,8'h1d,8'h09,8'h1f,8'h18,8'h0a,8'h1b,8'h2d,8'h00},
            '{8'h13,8'h16,8'h15,8'h1e,8'h17,8'h05,8'h04,8'h1c,8'h6a,8'h65,8'h00}
        },
        '{
            '{8'h54,8'h6d,8'h25,8'h7b,8'h22,8'h37,8'h61,8'h5a,8'h7f,8'h63,8'h10},
            '{8'h00,8'h28,8'h50,8'h33,8'h66,8'h32,8'h64,8'h29,8'h52,8'h2a,8'h00},
            '{8'h1a,8'h4a,8'h55,8'h47,8'h72,8'h2e,8'h35,8'h5e,8'h3d,8'h2d,8'h00},
            '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h73,8'h4c,8'h1c,8'h6a,8'h65,8'h00}
        },
        '{
            '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h10},
            '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
            '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
            '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
        }
    };

    // Key codes per panel, [panel][row][col]
    localparam t_rom_row KEY_ROM [0:3][0:3] = '{
        '{
            '{8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h08},
            '{8'h71,8'h77,8'h65,8'h72,8'h74,8'h79,8'h75,8'h69,8'h6f,8'h70,8'h7f},
            '{8'h61,8'h73,8'h64,8'h66,8'h67,8'h68,8'h6a,8'h6b,8'h6c,8'h2f,8'h11},
            '{8'h7a,8'h78,8'h63,8'h76,8'h62,8'h6e,8'h6d,8'h20,8'h2e,8'h40,8'h13}
        },
        '{
            '{8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h08},
            '{8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,8'h4f,8'h50,8'h7f},
            '{8'h41,8'h53,8'h44,8'h46,8'h47,8'h48,8'h4a,8'h4b,8'h4c,8'h2f,8'h11},
            '{8'h5a,8'h58,8'h43,8'h56,8'h42,8'h4e,8'h4d,8'h20,8'h2e,8'h40,8'h13}
        },
        '{
            '{8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,8'h60,8'h5e,8'h7e,8'h08},
            '{8'h09,8'h3c,8'h3e,8'h5b,8'h5d,8'h7b,8'h7d,8'h28,8'h29,8'h5c,8'h7f},
            '{8'h0d,8'h7c,8'h3b,8'h3a,8'h5f,8'h3d,8'h2b,8'h2d,8'h2a,8'h2f,8'h11},
            '{8'h0a,8'h2e,8'h2e,8'h2e,8'h2e,8'h3f,8'h2c,8'h20,8'h2e,8'h40,8'h13}
        },
        '{
            '{8'h80,8'h84,8'h88,8'h8c,8'h90,8'h94,8'h98,8'h9c,8'ha0,8'ha4,8'h08},
            '{8'h81,8'h85,8'h89,8'h8d,8'h91,8'h95,8'h99,8'h9d,8'ha1,8'ha5,8'h7f},
            '{8'h82,8'h86,8'h8a,8'h8e,8'h92,8'h96,8'h9a,8'h9e,8'ha2,8'ha6,8'h11},
            '{8'h83,8'h87,8'h8b,8'h8f,8'h93,8'h97,8'h9b,8'h9f,8'ha3,8'ha7,8'h13}
        }
    };

    // Morse set used by a panel
    function automatic logic [1:0] set_of_panel(input logic [1:0] panel);
        logic [1:0] s;
        begin
            unique case (panel)
                2'd0, 2'd1: s = 2'd0;
                2'd2:       s = 2'd1;
                default:    s = 2'd2;
            endcase
            return s;
        end
    endfunction

    // Panel whose keys a foreign set decodes to
    function automatic logic [1:0] panel_of_set(input logic [1:0] set);
        logic [1:0] p;
        begin
            unique case (set)
                2'd0:    p = 2'd0;
                2'd1:    p = 2'd2;
                default: p = 2'd3;
            endcase
            return p;
        end
    endfunction

endpackage

FILE: hw/rtl/mkle_cell.sv
module mkle_cell
    import mkle_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic [7:0] i_left,
    input  logic [7:0] i_right,
    output logic [7:0] o_char
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [7:0] r_char;

    // Take the key, the left neighbor on insert, the right neighbor on delete
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_INS: begin
                if (MY_POS == i_ctl.pos) begin
                    r_char <= i_ctl.ch;
                end else if (MY_POS > i_ctl.pos) begin
                    r_char <= i_left;
                end
            end
            OP_DEL: begin
                if (MY_POS >= i_ctl.pos) begin
                    r_char <= i_right;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_char = r_char;

endmodule

FILE: hw/rtl/mkle_line.sv
module mkle_line
    import mkle_pkg::*;
#(
    parameter int LINE_DEPTH = 64,
    parameter int IDX_W      = 6
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [7:0]       o_rd_char
);

    logic [7:0] w_char [0:LINE_DEPTH-1];

    // Row of character cells, each wired to both neighbors
    for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
        logic [7:0] w_left;
        logic [7:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = 8'h00;
        end else begin : g_mid_l
            assign w_left = w_char[g-1];
        end

        if (g == LINE_DEPTH - 1) begin : g_last
            assign w_right = 8'h00;
        end else begin : g_mid_r
            assign w_right = w_char[g+1];
        end

        mkle_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_char  (w_char[g])
        );
    end

    // Select the requested cell; range is checked by the caller
    assign o_rd_char = w_char[i_rd_idx];

endmodule

FILE: hw/rtl/morse_key_line_editor.sv
// Channel  | Handshake                    | Payload
// ---------+------------------------------+---------------------------------------------
// input    | i_in_valid / o_in_stall      | i_func i_panel i_key_code i_read_index
// output   | o_out_valid / i_out_stall    | o_key_valid o_key_out o_text_length
//          |                              | o_cursor_pos o_highlight_row/col o_read_char
// config   | i_cfg_we                     | i_cfg_index i_cfg_data
//
// One item at a time; the ROM compare port steps one row/column position per
// cycle through a highlight search or a decode.
// Line edits shift every character cell from the edit position on by one place at once.
// Synchronous active-low reset; no clearing pass. A stalled output holds its
// item while the next input item is already taken.
module morse_key_line_editor
    import mkle_pkg::*;
#(
    parameter int LINE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [1:0] i_panel,
    input  logic [7:0] i_key_code,
    input  logic [5:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_key_valid,
    output logic [7:0] o_key_out,
    output logic [6:0] o_text_length,
    output logic [6:0] o_cursor_pos,
    output logic [1:0] o_highlight_row,
    output logic [3:0] o_highlight_col,
    output logic [7:0] o_read_char,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    localparam int LEN_W = $clog2(LINE_DEPTH + 1);
    localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HL   = 3'd1;
    localparam logic [2:0] S_DEC1 = 3'd2;
    localparam logic [2:0] S_DEC2 = 3'd3;
    localparam logic [2:0] S_EDIT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic CFG_MAX_LEN = 1'b0;
    localparam logic CFG_EDIT_EN = 1'b1;

    logic [2:0]       r_state;
    logic [6:0]       r_max_len;
    logic             r_edit_en;
    logic [7:0]       r_pattern;
    logic [7:0]       r_dec_pat;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_cur;
    logic [1:0]       r_hi_row;
    logic [3:0]       r_hi_col;
    logic [1:0]       r_panel;
    logic [5:0]       r_ridx;
    logic [1:0]       r_row;
    logic [3:0]       r_col;
    logic [7:0]       r_key;
    logic             r_kvalid;

    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] n_cur;

    logic [1:0]       w_mp;
    logic [1:0]       w_o1;
    logic [1:0]       w_o2;
    logic [7:0]       w_cmp_pat;
    logic             w_hit;
    logic             w_hit1;
    logic             w_hit2;
    logic [7:0]       w_new_pat;
    logic             w_scan_end;
    logic [8:0]       w_cap;
    t_cell_ctl        w_ctl;
    logic [7:0]       w_rd_char;
    logic             w_rd_ok;
    logic             w_accept;
    logic             w_out_free;

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;

    // ROM compare port: current set, then both foreign sets together, the lower-numbered set winning a tie
    assign w_mp      = set_of_panel(r_panel);
    assign w_o1      = (w_mp == 2'd0) ? 2'd1 : 2'd0;
    assign w_o2      = (w_mp == 2'd2) ? 2'd1 : 2'd2;
    assign w_cmp_pat = (r_state == S_HL) ? r_pattern : r_dec_pat;
    assign w_hit     = CODE_ROM[w_mp][r_row][r_col] == w_cmp_pat;
    assign w_hit1    = CODE_ROM[w_o1][r_row][r_col] == w_cmp_pat;
    assign w_hit2    = CODE_ROM[w_o2][r_row][r_col] == w_cmp_pat;
    assign w_scan_end = (r_row == LAST_ROW) && (r_col == LAST_COL);

    // Next pattern for an element
    always_comb begin
        w_new_pat = (r_pattern == 8'h00) ? PAT_START : {r_pattern[6:0], 1'b0};
        w_new_pat[0] = w_new_pat[0] | (i_func == FUNC_SHORT);
    end

    // Edit command to the cells and the new length and cursor
    assign w_cap = (9'(r_max_len) > 9'(LINE_DEPTH)) ? 9'(LINE_DEPTH) : 9'(r_max_len);

    always_comb begin
        w_ctl.op  = OP_HOLD;
        w_ctl.pos = POS_W'(r_cur);
        w_ctl.ch  = r_key;
        n_len     = r_len;
        n_cur     = r_cur;
        if (r_state == S_EDIT && r_edit_en && r_kvalid) begin
            if (r_key == K_BS) begin
                if (r_cur != '0) begin
                    w_ctl.op  = OP_DEL;
                    w_ctl.pos = POS_W'(r_cur) - POS_W'(1);
                    n_len     = r_len - LEN_W'(1);
                    n_cur     = r_cur - LEN_W'(1);
                end
            end else if (r_key == K_DEL) begin
                if (r_cur < r_len) begin
                    w_ctl.op = OP_DEL;
                    n_len    = r_len - LEN_W'(1);
                end
            end else if (r_key == K_LEFT) begin
                if (r_cur != '0) begin
                    n_cur = r_cur - LEN_W'(1);
                end
            end else if (r_key == K_RIGHT) begin
                if (r_cur < r_len) begin
                    n_cur = r_cur + LEN_W'(1);
                end
            end else if (9'(r_len) < w_cap) begin
                w_ctl.op = OP_INS;
                n_len    = r_len + LEN_W'(1);
                n_cur    = r_cur + LEN_W'(1);
            end
        end
    end

    mkle_line #(
        .LINE_DEPTH (LINE_DEPTH),
        .IDX_W      (IDX_W)
    ) u_line (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_rd_idx  (IDX_W'(r_ridx)),
        .o_rd_char (w_rd_char)
    );

    assign w_rd_ok = (9'(r_ridx) < 9'(r_len)) && (9'(r_ridx) < 9'(LINE_DEPTH));

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_len   <= 7'd52;
            r_edit_en   <= 1'b1;
            r_pattern   <= 8'h00;
            r_len       <= '0;
            r_cur       <= '0;
            r_hi_row    <= 2'd0;
            r_hi_col    <= 4'd0;
            o_out_valid <= 1'b0;
        end else begin
            // Take configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_LEN: r_max_len <= i_cfg_data;
                    CFG_EDIT_EN: r_edit_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            // Drop the output item once taken, unless a new one replaces it
            if (o_out_valid && !i_out_stall && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_panel  <= i_panel;
                        r_ridx   <= i_read_index;
                        r_row    <= 2'd0;
                        r_col    <= 4'd0;
                        r_kvalid <= 1'b0;
                        r_key    <= 8'h00;
                        if (i_func == FUNC_SHORT || i_func == FUNC_LONG) begin
                            if (w_new_pat[7]) begin
                                r_dec_pat <= w_new_pat;
                                r_pattern <= 8'h00;
                                r_state   <= S_DEC1;
                            end else begin
                                r_pattern <= w_new_pat;
                                r_state   <= S_HL;
                            end
                        end else if (i_func == FUNC_END) begin
                            if (r_pattern != 8'h00) begin
                                r_dec_pat <= r_pattern;
                                r_pattern <= 8'h00;
                                r_state   <= S_DEC1;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_key    <= i_key_code;
                            r_kvalid <= 1'b1;
                            r_state  <= S_EDIT;
                        end
                    end
                end
                S_HL: begin
                    // Row-major search of the current set
                    if (w_hit) begin
                        r_hi_row <= r_row;
                        r_hi_col <= r_col;
                        r_state  <= S_OUT;
                    end else if (w_scan_end) begin
                        r_hi_row <= LAST_ROW;
                        r_hi_col <= LAST_COL;
                        r_state  <= S_OUT;
                    end else if (r_col == LAST_COL) begin
                        r_col <= 4'd0;
                        r_row <= r_row + 2'd1;
                    end else begin
                        r_col <= r_col + 4'd1;
                    end
                end
                S_DEC1: begin
                    // Column-major search of the current set
                    if (w_hit) begin
                        r_key    <= KEY_ROM[r_panel][r_row][r_col];
                        r_kvalid <= 1'b1;
                        r_state  <= S_EDIT;
                    end else if (w_scan_end) begin
                        r_row   <= 2'd0;
                        r_col   <= 4'd0;
                        r_state <= S_DEC2;
                    end else if (r_row == LAST_ROW) begin
                        r_row <= 2'd0;
                        r_col <= r_col + 4'd1;
                    end else begin
                        r_row <= r_row + 2'd1;
                    end
                end
                S_DEC2: begin
                    // Column-major search of the foreign sets
                    if (w_hit1) begin
                        r_key    <= KEY_ROM[panel_of_set(w_o1)][r_row][r_col];
                        r_kvalid <= 1'b1;
                        r_state  <= S_EDIT;
                    end else if (w_hit2) begin
                        r_key    <= KEY_ROM[panel_of_set(w_o2)][r_row][r_col];
                        r_kvalid <= 1'b1;
                        r_state  <= S_EDIT;
                    end else if (w_scan_end) begin
                        r_hi_row <= LAST_ROW;
                        r_hi_col <= LAST_COL;
                        r_state  <= S_OUT;
                    end else if (r_row == LAST_ROW) begin
                        r_row <= 2'd0;
                        r_col <= r_col + 4'd1;
                    end else begin
                        r_row <= r_row + 2'd1;
                    end
                end
                S_EDIT: begin
                    r_len   <= n_len;
                    r_cur   <= n_cur;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (w_out_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            o_key_valid     <= r_kvalid;
            o_key_out       <= r_kvalid ? r_key : 8'h00;
            o_text_length   <= 7'(r_len);
            o_cursor_pos    <= 7'(r_cur);
            o_highlight_row <= r_hi_row;
            o_highlight_col <= r_hi_col;
            o_read_char     <= w_rd_ok ? w_rd_char : 8'h00;
        end
    end

endmodule

FILE: hw/rtl/mkle_chk.sv
`include "assert_macros.svh"

module mkle_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_key_valid,
    input logic [7:0] o_key_out,
    input logic [6:0] o_text_length,
    input logic [6:0] o_cursor_pos
);

    // Reset empties the output register
    `AST_NXT_ALL(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)

    // A stalled item stays and holds its key
    `AST_NXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_key_out))

    // Cursor never passes the end of the line
    `AST_IMP(a_cursor_range, i_clk, i_rst_n, o_out_valid, o_cursor_pos <= o_text_length)

    // No key means a zero key code
    `AST_IMP(a_no_key_zero, i_clk, i_rst_n, o_out_valid && !o_key_valid, o_key_out == 8'h00)

endmodule

bind morse_key_line_editor mkle_chk u_mkle_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_key_valid   (o_key_valid),
    .o_key_out     (o_key_out),
    .o_text_length (o_text_length),
    .o_cursor_pos  (o_cursor_pos)
);
